// ===== design/acc_tilt_pkg.sv =====
`timescale 1ns / 1ps
package acc_tilt_pkg;

	localparam int REG_W = 16;
	localparam int ANGLE_W = 16;
	localparam int ROLL_W = 15;
	localparam int OUT_W = 32;

	localparam logic [0:0] REG_MOUNT_COS = 1'b0;
	localparam logic [0:0] REG_MOUNT_SIN = 1'b1;

	localparam logic signed [REG_W-1:0] MOUNT_COS_RST = 16'sd30792;
	localparam logic signed [REG_W-1:0] MOUNT_SIN_RST = -16'sd11207;

	localparam int CORDIC_STEPS = 24;
	localparam int ISQRT_STEPS = 32;
	localparam int ATAN_LAT = 4 + CORDIC_STEPS + 3;
	localparam int NORM_BIT = 40;

	localparam logic signed [31:0] DEG90_E7 = 32'sd900000000;
	localparam logic [16:0] HALF_CENTIDEG = 17'd50000;
	localparam logic [26:0] RECIP_3125 = 27'd87960931;
	localparam int RECIP_SHIFT = 38;

	localparam logic [29:0] ATAN_E7 [CORDIC_STEPS] = '{
		30'd450000000, 30'd265650512, 30'd140362435, 30'd71250163, 30'd35763344,
		30'd17899106, 30'd8951737, 30'd4476142, 30'd2238105, 30'd1119057,
		30'd559529, 30'd279765, 30'd139882, 30'd69941, 30'd34971,
		30'd17485, 30'd8743, 30'd4371, 30'd2186, 30'd1093,
		30'd546, 30'd273, 30'd137, 30'd68
	};

endpackage

// ===== design/acc_tilt_atan2.sv =====
`timescale 1ns / 1ps
module acc_tilt_atan2 #(
	parameter int IW = 33
) (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic signed [IW-1:0]                       y_in,
	input  logic signed [IW-1:0]                       x_in,
	output logic signed [acc_tilt_pkg::ANGLE_W-1:0]    ang
);

	localparam int NB = acc_tilt_pkg::NORM_BIT;
	localparam int CW = (IW + 3 > NB + 4) ? IW + 3 : NB + 4;
	localparam int ZW = 32;
	localparam int NW = ZW - 6;
	localparam int PW = NW + 27;
	localparam int QW = PW - acc_tilt_pkg::RECIP_SHIFT;
	localparam int NS = acc_tilt_pkg::CORDIC_STEPS;

	logic signed [CW-1:0] xe, ye, x_pre, y_pre;
	logic signed [ZW-1:0] z_pre;

	logic signed [CW-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic signed [ZW-1:0] z_s1, z_s2, z_s3, z_s4;
	logic                 zero_s1, zero_s2, zero_s3, zero_s4;
	logic [CW-1:0]        ax, ay, m_s2, m_s3;
	logic [CW-1:0]        m_n3, m_n4;
	logic signed [CW-1:0] x_n3, y_n3, x_n4, y_n4;

	logic signed [CW-1:0] cx_s [NS];
	logic signed [CW-1:0] cy_s [NS];
	logic signed [ZW-1:0] cz_s [NS];
	logic                 cf_s [NS];

	logic [ZW-1:0]        zmag, nsum;
	logic [NW-1:0]        nq_s29;
	logic                 neg_s29, neg_s30;
	logic [PW-1:0]        prod;
	logic [QW-1:0]        q_s30;

	always_comb begin
		xe = CW'(x_in);
		ye = CW'(y_in);
		if (xe < 0) begin
			if (ye >= 0) begin
				x_pre = ye;
				y_pre = -xe;
				z_pre = acc_tilt_pkg::DEG90_E7;
			end else begin
				x_pre = -ye;
				y_pre = xe;
				z_pre = -acc_tilt_pkg::DEG90_E7;
			end
		end else begin
			x_pre = xe;
			y_pre = ye;
			z_pre = '0;
		end
	end

	always_comb begin
		ax = (x_s1 < 0) ? CW'(-x_s1) : CW'(x_s1);
		ay = (y_s1 < 0) ? CW'(-y_s1) : CW'(y_s1);
	end

	// Left shift until the larger magnitude reaches the normalization bit.
	always_comb begin
		m_n3 = m_s2;
		x_n3 = x_s2;
		y_n3 = y_s2;
		for (int j = 0; j < 3; j++) begin
			if (m_n3 < (CW'(1) << (NB + 1 - (32 >> j)))) begin
				m_n3 = m_n3 << (32 >> j);
				x_n3 = x_n3 <<< (32 >> j);
				y_n3 = y_n3 <<< (32 >> j);
			end
		end
	end

	always_comb begin
		m_n4 = m_s3;
		x_n4 = x_s3;
		y_n4 = y_s3;
		for (int j = 3; j < 6; j++) begin
			if (m_n4 < (CW'(1) << (NB + 1 - (32 >> j)))) begin
				m_n4 = m_n4 << (32 >> j);
				x_n4 = x_n4 <<< (32 >> j);
				y_n4 = y_n4 <<< (32 >> j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_pre;
			y_s1 <= y_pre;
			z_s1 <= z_pre;
			zero_s1 <= (x_in == '0) && (y_in == '0);
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
			zero_s2 <= zero_s1;
			m_s2 <= (ax > ay) ? ax : ay;
			x_s3 <= x_n3;
			y_s3 <= y_n3;
			z_s3 <= z_s2;
			zero_s3 <= zero_s2;
			m_s3 <= m_n3;
			x_s4 <= x_n4;
			y_s4 <= y_n4;
			z_s4 <= z_s3;
			zero_s4 <= zero_s3;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic signed [CW-1:0] xi, yi;
		logic signed [ZW-1:0] zi;
		logic                 fi;
		if (i == 0) begin : g_first
			assign xi = x_s4;
			assign yi = y_s4;
			assign zi = z_s4;
			assign fi = zero_s4;
		end else begin : g_next
			assign xi = cx_s[i-1];
			assign yi = cy_s[i-1];
			assign zi = cz_s[i-1];
			assign fi = cf_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cf_s[i] <= fi;
				if (yi > 0) begin
					cx_s[i] <= xi + (yi >>> i);
					cy_s[i] <= yi - (xi >>> i);
					cz_s[i] <= zi + $signed({2'b00, acc_tilt_pkg::ATAN_E7[i]});
				end else begin
					cx_s[i] <= xi - (yi >>> i);
					cy_s[i] <= yi + (xi >>> i);
					cz_s[i] <= zi - $signed({2'b00, acc_tilt_pkg::ATAN_E7[i]});
				end
			end
		end
	end

	// Round half away from zero to hundredths of a degree; the divide by
	// 100000 is a shift by 5 and a reciprocal multiply for 3125.
	always_comb begin
		zmag = (cz_s[NS-1] < 0) ? ZW'(-cz_s[NS-1]) : ZW'(cz_s[NS-1]);
		if (cf_s[NS-1]) begin
			zmag = '0;
		end
		nsum = zmag + ZW'(acc_tilt_pkg::HALF_CENTIDEG);
		prod = PW'(nq_s29) * PW'(acc_tilt_pkg::RECIP_3125);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nq_s29 <= nsum[ZW-2:5];
			neg_s29 <= cz_s[NS-1] < 0;
			q_s30 <= prod[PW-1:acc_tilt_pkg::RECIP_SHIFT];
			neg_s30 <= neg_s29;
			ang <= neg_s30 ? -acc_tilt_pkg::ANGLE_W'(q_s30) : acc_tilt_pkg::ANGLE_W'(q_s30);
		end
	end

endmodule

// ===== design/accel_tilt_attitude.sv =====
`timescale 1ns / 1ps
// Throughput is one beat per cycle while the output is not stalled by m_tready;
// the 24-step CORDIC units and the 32-step square root are fully pipelined
// and a skid register sits at the input.
// Reset clears all valid bits and loads the mount registers with the cosine
// and sine of a -20 degree mounting angle.
module accel_tilt_attitude #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [0:0]                               cfg_addr,
	input  logic [acc_tilt_pkg::REG_W-1:0]           cfg_wdata,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// Fields from bit 0 up: accel_x, accel_y, accel_z, zero fill.
	input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// Fields from bit 0 up: pitch_centideg, roll_centideg, zero fill.
	output logic [acc_tilt_pkg::OUT_W-1:0]           m_tdata
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int PRW = SW + acc_tilt_pkg::REG_W;
	localparam int RW = SW + 17;
	localparam int SMAX = (RW > 31) ? RW - 31 : 0;
	localparam int SHW = $clog2(SMAX + 2);
	localparam int NQ = acc_tilt_pkg::ISQRT_STEPS;
	localparam int DLY = 4 + NQ;
	localparam int LAT = 2 + DLY + acc_tilt_pkg::ATAN_LAT + 1;
	localparam logic signed [63:0] MAGLIM = 64'sh0000_0000_8000_0000;

	logic signed [acc_tilt_pkg::REG_W-1:0] mount_cos_q, mount_sin_q;

	logic              en, pipe_v, skid_v_q;
	logic [3*SW-1:0]   skid_data_q, pipe_d;
	logic [LAT:1]      v_s;

	logic signed [SW-1:0]  ax_in, ay_in, az_in;
	logic signed [PRW-1:0] pxc_s1, pzs_s1, pzc_s1, pxs_s1;
	logic signed [SW-1:0]  y_s1, y_s2;
	logic signed [RW-1:0]  xr_s2, zr_s2, yq_w;
	logic [SHW-1:0]        sh_n, sh_s3;
	logic signed [RW-1:0]  xr_s3, zr_s3, yq_s3;
	logic signed [RW-1:0]  px, pz;
	logic [RW-1:0]         apx, apz;
	logic [30:0]           amx_s4, amz_s4;
	logic signed [31:0]    yq_s4, yq_s5, yq_s6;
	logic [61:0]           sqx_s5, sqz_s5;
	logic [62:0]           sqn_s6;

	logic [63:0]        sq_n_s [NQ];
	logic [63:0]        sq_r_s [NQ];
	logic signed [31:0] sq_y_s [NQ];

	logic signed [acc_tilt_pkg::ANGLE_W-1:0] pitch_a, roll_a;
	logic signed [acc_tilt_pkg::ANGLE_W-1:0] pitch_d_s [DLY];
	logic signed [acc_tilt_pkg::ANGLE_W-1:0] pitch_s70;
	logic signed [acc_tilt_pkg::ROLL_W-1:0]  roll_s70;

	function automatic logic fits(input logic signed [RW-1:0] w, input int s);
		logic signed [63:0] t;
		t = 64'(w >>> s);
		return (t < MAGLIM) && (t > -MAGLIM);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_cos_q <= acc_tilt_pkg::MOUNT_COS_RST;
			mount_sin_q <= acc_tilt_pkg::MOUNT_SIN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				acc_tilt_pkg::REG_MOUNT_COS: mount_cos_q <= cfg_wdata;
				acc_tilt_pkg::REG_MOUNT_SIN: mount_sin_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en = !m_tvalid || m_tready;
	assign s_tready = !skid_v_q;
	assign pipe_v = skid_v_q || s_tvalid;
	assign pipe_d = skid_v_q ? skid_data_q : s_tdata[3*SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
			v_s <= '0;
		end else if (en) begin
			skid_v_q <= 1'b0;
			v_s <= {v_s[LAT-1:1], pipe_v};
		end else if (s_tvalid && s_tready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && s_tvalid && s_tready) begin
			skid_data_q <= s_tdata[3*SW-1:0];
		end
	end

	assign ax_in = pipe_d[SW-1:0];
	assign ay_in = pipe_d[2*SW-1:SW];
	assign az_in = pipe_d[3*SW-1:2*SW];
	assign yq_w = {{2{y_s2[SW-1]}}, y_s2, 15'b0};

	// Smallest common right shift that brings all three magnitudes below 2^31.
	always_comb begin
		sh_n = SHW'(SMAX);
		for (int s = SMAX; s >= 0; s--) begin
			if (fits(xr_s2, s) && fits(zr_s2, s) && fits(yq_w, s)) begin
				sh_n = SHW'(s);
			end
		end
	end

	always_comb begin
		px = xr_s3 >>> sh_s3;
		pz = zr_s3 >>> sh_s3;
		apx = (px < 0) ? RW'(-px) : RW'(px);
		apz = (pz < 0) ? RW'(-pz) : RW'(pz);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxc_s1 <= ax_in * mount_cos_q;
			pzs_s1 <= az_in * mount_sin_q;
			pzc_s1 <= az_in * mount_cos_q;
			pxs_s1 <= ax_in * mount_sin_q;
			y_s1 <= ay_in;
			xr_s2 <= RW'(pxc_s1) + RW'(pzs_s1);
			zr_s2 <= RW'(pzc_s1) - RW'(pxs_s1);
			y_s2 <= y_s1;
			sh_s3 <= sh_n;
			xr_s3 <= xr_s2;
			zr_s3 <= zr_s2;
			yq_s3 <= yq_w;
			amx_s4 <= 31'(apx);
			amz_s4 <= 31'(apz);
			yq_s4 <= 32'(yq_s3 >>> sh_s3);
			sqx_s5 <= 62'(amx_s4) * 62'(amx_s4);
			sqz_s5 <= 62'(amz_s4) * 62'(amz_s4);
			yq_s5 <= yq_s4;
			sqn_s6 <= 63'(sqx_s5) + 63'(sqz_s5);
			yq_s6 <= yq_s5;
		end
	end

	for (genvar k = 0; k < NQ; k++) begin : g_isqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0]        ni, ri, rb;
		logic signed [31:0] yi;
		if (k == 0) begin : g_first
			assign ni = 64'(sqn_s6);
			assign ri = '0;
			assign yi = yq_s6;
		end else begin : g_next
			assign ni = sq_n_s[k-1];
			assign ri = sq_r_s[k-1];
			assign yi = sq_y_s[k-1];
		end
		assign rb = ri + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_y_s[k] <= yi;
				if (ni >= rb) begin
					sq_n_s[k] <= ni - rb;
					sq_r_s[k] <= (ri >> 1) + BIT;
				end else begin
					sq_n_s[k] <= ni;
					sq_r_s[k] <= ri >> 1;
				end
			end
		end
	end

	acc_tilt_atan2 #(
		.IW (RW)
	) u_pitch (
		.clk  (clk),
		.en   (en),
		.y_in (zr_s2),
		.x_in (xr_s2),
		.ang  (pitch_a)
	);

	acc_tilt_atan2 #(
		.IW (33)
	) u_roll (
		.clk  (clk),
		.en   (en),
		.y_in (33'(sq_y_s[NQ-1])),
		.x_in ($signed({1'b0, sq_r_s[NQ-1][31:0]})),
		.ang  (roll_a)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_d_s[0] <= -pitch_a;
			for (int k = 1; k < DLY; k++) begin
				pitch_d_s[k] <= pitch_d_s[k-1];
			end
			pitch_s70 <= pitch_d_s[DLY-1];
			roll_s70 <= roll_a[acc_tilt_pkg::ROLL_W-1:0];
		end
	end

	assign m_tvalid = v_s[LAT];
	assign m_tdata = {1'b0, roll_s70, pitch_s70};

`ifndef SYNTH
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && en |=> !skid_v_q)
		else $error("Skid register did not drain when the pipeline advanced.");
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !en |=> skid_v_q)
		else $error("Beat taken during a stall was not held in the skid register.");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pitch_s70 >= -16'sd18000) && (pitch_s70 <= 16'sd18000))
		else $error("Pitch out of range.");
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (roll_s70 >= -15'sd9000) && (roll_s70 <= 15'sd9000))
		else $error("Roll out of range.");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

	localparam int SW = 16;
	localparam int IN_W = ((3*SW+7)/8)*8;
	localparam longint NORM_LIM = 64'sd1 << 40;
	localparam longint MAG_LIM = 64'sd1 << 31;

	typedef struct packed {
		logic signed [SW-1:0] az;
		logic signed [SW-1:0] ay;
		logic signed [SW-1:0] ax;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] roll;
		logic signed [15:0] pitch;
	} attitude_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_addr = acc_tilt_pkg::REG_MOUNT_COS;
	logic [acc_tilt_pkg::REG_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [acc_tilt_pkg::OUT_W-1:0] m_tdata;

	sample_t pending_samples[$];
	attitude_t expected_attitudes[$];
	logic signed [acc_tilt_pkg::REG_W-1:0] cur_cos, cur_sin;
	int errors = 0;
	bit hold_send = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	longint atan_step[acc_tilt_pkg::CORDIC_STEPS] = '{
		450000000, 265650512, 140362435, 71250163, 35763344, 17899106,
		8951737, 4476142, 2238105, 1119057, 559529, 279765,
		139882, 69941, 34971, 17485, 8743, 4371,
		2186, 1093, 546, 273, 137, 68
	};

	accel_tilt_attitude #(.SAMPLE_WIDTH(SW)) dut (.*);

	always #5 clk = ~clk;

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint atan2_1e7deg(longint y, longint x);
		longint z, t, xs, ys, m;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				z = 900000000; x = y; y = -t;
			end else begin
				z = -900000000; x = -y; y = t;
			end
		end
		m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
		while (m < NORM_LIM) begin
			m = m <<< 1; x = x * 2; y = y * 2;
		end
		for (int i = 0; i < acc_tilt_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += atan_step[i];
			end else begin
				x -= ys; y += xs; z -= atan_step[i];
			end
		end
		return z;
	endfunction

	function automatic longint isqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b; r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint centideg(longint a);
		if (a >= 0)
			return (a + 50000) / 100000;
		return -((-a + 50000) / 100000);
	endfunction

	function automatic attitude_t tilt_of(sample_t s);
		longint x, y, z, c, sn, xr, zr, yq;
		attitude_t r;
		x = s.ax; y = s.ay; z = s.az;
		c = cur_cos; sn = cur_sin;
		xr = x * c + z * sn;
		zr = z * c - x * sn;
		yq = y * 32768;
		r.pitch = 16'(-centideg(atan2_1e7deg(zr, xr)));
		while (abs64(xr) >= MAG_LIM || abs64(zr) >= MAG_LIM || abs64(yq) >= MAG_LIM) begin
			xr = xr >>> 1; zr = zr >>> 1; yq = yq >>> 1;
		end
		r.roll = 15'(centideg(atan2_1e7deg(yq, isqrt(xr * xr + zr * zr))));
		return r;
	endfunction

	function automatic int rand_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Driver: predicts each sample as it is accepted so configuration order holds.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_attitudes.push_back(tilt_of(s_tdata[3*SW-1:0]));
			void'(pending_samples.pop_front());
			send_gap <= rand_gap();
		end
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !s_tready) begin
			s_tvalid <= 1'b1;
		end else begin
			if (send_gap > 0 && !(s_tvalid && s_tready))
				send_gap <= send_gap - 1;
			if (!hold_send && pending_samples.size() > 0
					&& (send_gap == 0 || s_tvalid) && !(s_tvalid && rand_gap() != 0)) begin
				s_tvalid <= 1'b1;
				s_tdata <= IN_W'(pending_samples[0]);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		attitude_t got, exp_a;
		if (m_tvalid && m_tready) begin
			got = m_tdata[30:0];
			if (expected_attitudes.size() == 0) begin
				$display("%0t: unexpected result pitch=%0d roll=%0d", $time, got.pitch, got.roll);
				errors++;
			end else begin
				exp_a = expected_attitudes.pop_front();
				if (got.pitch !== exp_a.pitch) begin
					$display("%0t: pitch expected %0d actual %0d", $time, exp_a.pitch, got.pitch);
					errors++;
				end
				if (got.roll !== exp_a.roll) begin
					$display("%0t: roll expected %0d actual %0d", $time, exp_a.roll, got.roll);
					errors++;
				end
				if (m_tdata[acc_tilt_pkg::OUT_W-1:31] !== '0) begin
					$display("%0t: fill expected 0 actual %0h", $time,
						m_tdata[acc_tilt_pkg::OUT_W-1:31]);
					errors++;
				end
			end
		end
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			recv_gap <= rand_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	task automatic wait_drained();
		while (pending_samples.size() != 0 || s_tvalid || expected_attitudes.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_mount(logic [0:0] idx, logic signed [acc_tilt_pkg::REG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == acc_tilt_pkg::REG_MOUNT_COS) cur_cos = v;
		else cur_sin = v;
		@(posedge clk);
	endtask

	function automatic logic signed [SW-1:0] rand_axis();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(int'($urandom_range(0, 6)) - 3);
			3: return 16'(int'($urandom_range(0, 4000)) - 2000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_sample(logic signed [SW-1:0] x, y, z);
		sample_t s;
		s.ax = x; s.ay = y; s.az = z;
		pending_samples.push_back(s);
	endtask

	initial begin
		logic signed [acc_tilt_pkg::REG_W-1:0] cos_set[6], sin_set[6];
		cos_set = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd23170, 16'sd100, 16'sd30792};
		sin_set = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd23170, -16'sd5, -16'sd11207};
		cur_cos = acc_tilt_pkg::MOUNT_COS_RST;
		cur_sin = acc_tilt_pkg::MOUNT_SIN_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		add_sample(0, 0, 0);
		add_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		add_sample(16'sh8000, 16'sh8000, 16'sh8000);
		add_sample(16'sh7FFF, 0, 16'sh8000);
		add_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF);
		add_sample(0, 16'sd1000, 0);
		add_sample(0, -16'sd1000, 0);
		add_sample(16'sd1, 16'sd2, -16'sd1);
		wait_drained();
		// Axis cases: rotated Z zero with X negative and positive, a zero rotated vector, and rotated X zero.
		write_mount(acc_tilt_pkg::REG_MOUNT_COS, 16'sh7FFF);
		write_mount(acc_tilt_pkg::REG_MOUNT_SIN, 16'sd0);
		add_sample(-16'sd500, 16'sd0, 16'sd0);
		add_sample(16'sh8000, 16'sd7, 16'sd0);
		add_sample(16'sd500, 16'sd0, 16'sd0);
		add_sample(16'sd0, 16'sh8000, 16'sd0);
		add_sample(16'sd0, 16'sd0, 16'sh8000);
		wait_drained();
		write_mount(acc_tilt_pkg::REG_MOUNT_COS, 16'sd0);
		add_sample(16'sd40, 16'sd0, 16'sd100);
		add_sample(16'sd40, 16'sd3, -16'sd100);
		wait_drained();
		for (int ph = 0; ph < 6; ph++) begin
			write_mount(acc_tilt_pkg::REG_MOUNT_COS, cos_set[ph]);
			write_mount(acc_tilt_pkg::REG_MOUNT_SIN, sin_set[ph]);
			for (int i = 0; i < 200; i++)
				add_sample(rand_axis(), rand_axis(), rand_axis());
			if (ph == 2) begin
				while (pending_samples.size() > 100) @(posedge clk);
				hold_send = 1'b1;
				while (expected_attitudes.size() != 0 || s_tvalid) @(posedge clk);
				hold_send = 1'b0;
			end
			wait_drained();
		end
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== accel_tilt_attitude.f =====
design/acc_tilt_pkg.sv
design/acc_tilt_atan2.sv
design/accel_tilt_attitude.sv
sim/tb_top.sv
